// ===== design/quaternion_trs_model_matrix_defines.svh =====
// Assertion macros used by the port-level checker of the model-matrix block.
`ifndef QUATERNION_TRS_MODEL_MATRIX_DEFINES_SVH
`define QUATERNION_TRS_MODEL_MATRIX_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define QTRS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("qtrs assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define QTRS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("qtrs assertion failed");

`endif

// ===== design/qtrs_pkg.sv =====
// Types and constants for the quaternion TRS model-matrix pipeline.
`timescale 1ns / 1ps
package qtrs_pkg;

  localparam int QW      = 16;              // quaternion component, Q2.14
  localparam int POS_W   = 32;              // translation, Q16.16
  localparam int SC_W    = 24;              // axis scale, unsigned Q8.16
  localparam int PROD_W  = 2 * QW;          // quaternion product, Q.28
  localparam int ROT_W   = PROD_W + 2;      // rotation element, Q.28
  localparam int MUL_W   = ROT_W + SC_W + 1; // rotation times scale, Q.44
  localparam int OUT_W   = 32;              // result, Q16.16
  localparam int FRAC_DROP = 28;
  localparam int RES_W   = MUL_W - FRAC_DROP;
  localparam int NUM_PROD = 9;
  localparam int NUM_ROT  = 9;
  localparam int PIPE_DEPTH = 4;

  // 1.0 in Q.28
  localparam logic signed [ROT_W-1:0] ONE_Q28 = ROT_W'(64'sd1 <<< FRAC_DROP);
  // half an LSB of the result, for round to nearest
  localparam logic signed [MUL_W-1:0] HALF_LSB = MUL_W'(64'sd1 <<< (FRAC_DROP - 1));

  // product slots
  localparam int P_XX = 0;
  localparam int P_YY = 1;
  localparam int P_ZZ = 2;
  localparam int P_XY = 3;
  localparam int P_XZ = 4;
  localparam int P_YZ = 5;
  localparam int P_WX = 6;
  localparam int P_WY = 7;
  localparam int P_WZ = 8;

  typedef logic signed [QW-1:0]     quat_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic        [SC_W-1:0]   scale_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ROT_W-1:0]  rot_t;
  typedef logic signed [MUL_W-1:0]  mul_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  // 2 * (a + b) or 2 * (a - b), exact in ROT_W bits
  function automatic rot_t twice_sum(input prod_t a, input prod_t b, input logic sub);
    rot_t ea;
    rot_t eb;
    rot_t s;
    ea = {{2{a[PROD_W-1]}}, a};
    eb = {{2{b[PROD_W-1]}}, b};
    s  = sub ? (ea - eb) : (ea + eb);
    return {s[ROT_W-2:0], 1'b0};
  endfunction

endpackage

// ===== design/quaternion_trs_model_matrix.sv =====
// Top level: quaternion, position and scale to a scaled 3x4 model matrix.
// An input beat passes the stage-1, stage-2, stage-3 and stage-4 registers in turn to the result.
// Throughput: one beat per cycle while out_ready lets beats leave; the stage-3 multipliers
// (rotation x scale) and the stage-1 quaternion multipliers set the cycle, at most one multiply deep per stage.
// Each stage holds its beat while the stage after it is full; bubbles close up.
// Reset (rst_n low, synchronous) empties every stage; payload is not reset.
`timescale 1ns / 1ps
module quaternion_trs_model_matrix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [qtrs_pkg::QW-1:0]    in_quat_w,
  input  logic signed [qtrs_pkg::QW-1:0]    in_quat_x,
  input  logic signed [qtrs_pkg::QW-1:0]    in_quat_y,
  input  logic signed [qtrs_pkg::QW-1:0]    in_quat_z,
  input  logic signed [qtrs_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [qtrs_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [qtrs_pkg::POS_W-1:0] in_pos_z,
  input  logic        [qtrs_pkg::SC_W-1:0]  in_scale_x,
  input  logic        [qtrs_pkg::SC_W-1:0]  in_scale_y,
  input  logic        [qtrs_pkg::SC_W-1:0]  in_scale_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_x_axis_x,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_x_axis_y,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_x_axis_z,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_y_axis_x,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_y_axis_y,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_y_axis_z,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_z_axis_x,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_z_axis_y,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_z_axis_z,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_trans_x,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_trans_y,
  output logic signed [qtrs_pkg::OUT_W-1:0] out_trans_z
);
  import qtrs_pkg::*;

  // stage valid bits
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic v4_r, v4_nxt;

  // stage enables
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1: quaternion products
  prod_t  prod1_r  [NUM_PROD];
  prod_t  prod1_nxt[NUM_PROD];
  scale_t sc1_r    [3];
  scale_t sc1_nxt  [3];
  pos_t   pos1_r   [3];
  pos_t   pos1_nxt [3];

  // stage 2: rotation elements, column-major
  rot_t   rot2_r   [NUM_ROT];
  rot_t   rot2_nxt [NUM_ROT];
  scale_t sc2_r    [3];
  pos_t   pos2_r   [3];

  // stage 3: scaled elements before rounding
  mul_t   mul3_r   [NUM_ROT];
  mul_t   mul3_nxt [NUM_ROT];
  pos_t   pos3_r   [3];

  // stage 4: output register
  res_t   res4_r   [NUM_ROT];
  res_t   res4_nxt [NUM_ROT];
  pos_t   pos4_r   [3];

  // a stage may load when it is empty or its beat moves on
  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    v1_nxt = rdy1 ? in_valid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
    v4_nxt = rdy4 ? v3_r : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // ---- stage 1 ----
  always_comb begin
    prod1_nxt[P_XX] = in_quat_x * in_quat_x;
    prod1_nxt[P_YY] = in_quat_y * in_quat_y;
    prod1_nxt[P_ZZ] = in_quat_z * in_quat_z;
    prod1_nxt[P_XY] = in_quat_x * in_quat_y;
    prod1_nxt[P_XZ] = in_quat_x * in_quat_z;
    prod1_nxt[P_YZ] = in_quat_y * in_quat_z;
    prod1_nxt[P_WX] = in_quat_w * in_quat_x;
    prod1_nxt[P_WY] = in_quat_w * in_quat_y;
    prod1_nxt[P_WZ] = in_quat_w * in_quat_z;
    sc1_nxt[0]  = in_scale_x;
    sc1_nxt[1]  = in_scale_y;
    sc1_nxt[2]  = in_scale_z;
    pos1_nxt[0] = in_pos_x;
    pos1_nxt[1] = in_pos_y;
    pos1_nxt[2] = in_pos_z;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod1_r <= prod1_nxt;
      sc1_r   <= sc1_nxt;
      pos1_r  <= pos1_nxt;
    end
  end

  // ---- stage 2 ----
  always_comb begin
    rot2_nxt[0] = ONE_Q28 - twice_sum(prod1_r[P_YY], prod1_r[P_ZZ], 1'b0);
    rot2_nxt[1] = twice_sum(prod1_r[P_XY], prod1_r[P_WZ], 1'b0);
    rot2_nxt[2] = twice_sum(prod1_r[P_XZ], prod1_r[P_WY], 1'b1);
    rot2_nxt[3] = twice_sum(prod1_r[P_XY], prod1_r[P_WZ], 1'b1);
    rot2_nxt[4] = ONE_Q28 - twice_sum(prod1_r[P_XX], prod1_r[P_ZZ], 1'b0);
    rot2_nxt[5] = twice_sum(prod1_r[P_YZ], prod1_r[P_WX], 1'b0);
    rot2_nxt[6] = twice_sum(prod1_r[P_XZ], prod1_r[P_WY], 1'b0);
    rot2_nxt[7] = twice_sum(prod1_r[P_YZ], prod1_r[P_WX], 1'b1);
    rot2_nxt[8] = ONE_Q28 - twice_sum(prod1_r[P_XX], prod1_r[P_YY], 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rot2_r <= rot2_nxt;
      sc2_r  <= sc1_r;
      pos2_r <= pos1_r;
    end
  end

  // ---- stage 3 ----
  always_comb begin
    for (int i = 0; i < NUM_ROT; i++) begin
      mul3_nxt[i] = rot2_r[i] * $signed({1'b0, sc2_r[i / 3]});
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      mul3_r <= mul3_nxt;
      pos3_r <= pos2_r;
    end
  end

  // ---- stage 4 ----
  // Round half away from zero: negative values take one less than half an LSB
  // before the arithmetic shift. |rotation| <= 16 and scale < 256 keep the
  // rounded value within RES_W bits, so sign extension to 32 bits needs no clamp.
  always_comb begin
    for (int i = 0; i < NUM_ROT; i++) begin
      mul_t rnd;
      rnd = mul3_r[i] + HALF_LSB - MUL_W'(mul3_r[i][MUL_W-1]);
      res4_nxt[i] = OUT_W'($signed(rnd[MUL_W-1:FRAC_DROP]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      res4_r <= res4_nxt;
      pos4_r <= pos3_r;
    end
  end

  assign out_valid    = v4_r;
  assign out_x_axis_x = res4_r[0];
  assign out_x_axis_y = res4_r[1];
  assign out_x_axis_z = res4_r[2];
  assign out_y_axis_x = res4_r[3];
  assign out_y_axis_y = res4_r[4];
  assign out_y_axis_z = res4_r[5];
  assign out_z_axis_x = res4_r[6];
  assign out_z_axis_y = res4_r[7];
  assign out_z_axis_z = res4_r[8];
  assign out_trans_x  = pos4_r[0];
  assign out_trans_y  = pos4_r[1];
  assign out_trans_z  = pos4_r[2];

endmodule

// ===== design/qtrs_checker.sv =====
// Port-level checker for the model-matrix pipeline, bound to the top level.
`timescale 1ns / 1ps
`include "quaternion_trs_model_matrix_defines.svh"
module qtrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  import qtrs_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic in_beat, out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // beats inside the pipeline
  always_comb begin
    occ_nxt = occ_r;
    if (in_beat && !out_beat) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (out_beat && !in_beat) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  `QTRS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `QTRS_ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)
  `QTRS_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= CNT_W'(PIPE_DEPTH))
  `QTRS_ASSERT_IMP(a_no_phantom, out_valid, occ_r != '0)

endmodule

bind quaternion_trs_model_matrix qtrs_checker u_qtrs_checker (.*);

// ===== tb/qtrs_matrix_checker.sv =====
// Checker for the model-matrix block: predicts each matrix and compares result beats.
`timescale 1ns / 1ps
module qtrs_matrix_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  qtrs_pkg::quat_t  in_quat_w,
  input  qtrs_pkg::quat_t  in_quat_x,
  input  qtrs_pkg::quat_t  in_quat_y,
  input  qtrs_pkg::quat_t  in_quat_z,
  input  qtrs_pkg::pos_t   in_pos_x,
  input  qtrs_pkg::pos_t   in_pos_y,
  input  qtrs_pkg::pos_t   in_pos_z,
  input  qtrs_pkg::scale_t in_scale_x,
  input  qtrs_pkg::scale_t in_scale_y,
  input  qtrs_pkg::scale_t in_scale_z,
  input  logic             out_valid,
  input  logic             out_ready,
  input  qtrs_pkg::res_t   out_x_axis_x,
  input  qtrs_pkg::res_t   out_x_axis_y,
  input  qtrs_pkg::res_t   out_x_axis_z,
  input  qtrs_pkg::res_t   out_y_axis_x,
  input  qtrs_pkg::res_t   out_y_axis_y,
  input  qtrs_pkg::res_t   out_y_axis_z,
  input  qtrs_pkg::res_t   out_z_axis_x,
  input  qtrs_pkg::res_t   out_z_axis_y,
  input  qtrs_pkg::res_t   out_z_axis_z,
  input  qtrs_pkg::res_t   out_trans_x,
  input  qtrs_pkg::res_t   out_trans_y,
  input  qtrs_pkg::res_t   out_trans_z,
  output int               fail_count,
  output int               outstanding,
  output int               matrices_checked,
  output int               limit_elems
);
  import qtrs_pkg::*;

  localparam int NUM_ELEMS = 12;
  localparam longint ONE_Q28_L = 64'sd268435456;

  typedef res_t [NUM_ELEMS-1:0] matrix_t;

  matrix_t pending_matrices[$];

  string elem_name[NUM_ELEMS] = '{
    "x_axis_x", "x_axis_y", "x_axis_z",
    "y_axis_x", "y_axis_y", "y_axis_z",
    "z_axis_x", "z_axis_y", "z_axis_z",
    "trans_x", "trans_y", "trans_z"
  };

  // Q.28 rotation element times Q8.16 scale, rounded half away from zero to Q16.16
  function automatic res_t scale_to_q16(input longint rot_q28, input scale_t sc);
    longint prod;
    longint unsigned mag;
    longint unsigned q;
    prod = rot_q28 * longint'(sc);
    mag = (prod < 0) ? -prod : prod;
    q = (mag + 64'd134217728) >> 28;
    if (prod < 0)
      return (q > 64'd2147483648) ? res_t'(32'h8000_0000) : res_t'(-q);
    return (q > 64'd2147483647) ? res_t'(32'h7FFF_FFFF) : res_t'(q);
  endfunction

  function automatic matrix_t build_matrix(
    input quat_t qw, input quat_t qx, input quat_t qy, input quat_t qz,
    input pos_t px, input pos_t py, input pos_t pz,
    input scale_t sx, input scale_t sy, input scale_t sz
  );
    longint w, x, y, z;
    longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint rot[9];
    scale_t col_scale[3];
    matrix_t m;
    w = longint'(qw);
    x = longint'(qx);
    y = longint'(qy);
    z = longint'(qz);
    xx = x * x; yy = y * y; zz = z * z;
    xy = x * y; xz = x * z; yz = y * z;
    wx = w * x; wy = w * y; wz = w * z;
    // column-major: three rows of column 0, then column 1, then column 2
    rot[0] = ONE_Q28_L - 2 * (yy + zz);
    rot[1] = 2 * (xy + wz);
    rot[2] = 2 * (xz - wy);
    rot[3] = 2 * (xy - wz);
    rot[4] = ONE_Q28_L - 2 * (xx + zz);
    rot[5] = 2 * (yz + wx);
    rot[6] = 2 * (xz + wy);
    rot[7] = 2 * (yz - wx);
    rot[8] = ONE_Q28_L - 2 * (xx + yy);
    col_scale[0] = sx;
    col_scale[1] = sy;
    col_scale[2] = sz;
    for (int i = 0; i < 9; i++)
      m[i] = scale_to_q16(rot[i], col_scale[i / 3]);
    m[9]  = px;
    m[10] = py;
    m[11] = pz;
    return m;
  endfunction

  always @(posedge clk) begin : watch
    matrix_t want;
    matrix_t got;
    if (!rst_n) begin
      pending_matrices.delete();
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready)
        pending_matrices.push_back(build_matrix(in_quat_w, in_quat_x, in_quat_y, in_quat_z,
                                                in_pos_x, in_pos_y, in_pos_z,
                                                in_scale_x, in_scale_y, in_scale_z));
      if (out_valid && out_ready) begin
        got = {out_trans_z, out_trans_y, out_trans_x,
               out_z_axis_z, out_z_axis_y, out_z_axis_x,
               out_y_axis_z, out_y_axis_y, out_y_axis_x,
               out_x_axis_z, out_x_axis_y, out_x_axis_x};
        if (pending_matrices.size() == 0) begin
          $display("%0t: result beat with no transform outstanding", $time);
          fail_count++;
        end else begin
          want = pending_matrices.pop_front();
          matrices_checked++;
          for (int i = 0; i < NUM_ELEMS; i++) begin
            if (i < 9 && (want[i] == 32'h7FFF_FFFF || want[i] == 32'h8000_0000))
              limit_elems++;
            if (got[i] !== want[i]) begin
              $display("%0t: %s mismatch, expected %0d got %0d", $time, elem_name[i],
                       $signed(want[i]), $signed(got[i]));
              fail_count++;
            end
          end
        end
      end
      outstanding <= pending_matrices.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, transform stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module testbench;
  import qtrs_pkg::*;

  localparam int NUM_RANDOM = 950;
  localparam int MAX_IDLE = 18;
  localparam int LONG_HOLD = 150;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    quat_t  w, x, y, z;
    pos_t   px, py, pz;
    scale_t sx, sy, sz;
  } transform_t;

  logic   clk = 1'b0;
  logic   rst_n;
  logic   in_valid;
  logic   in_ready;
  quat_t  in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  pos_t   in_pos_x, in_pos_y, in_pos_z;
  scale_t in_scale_x, in_scale_y, in_scale_z;
  logic   out_valid;
  logic   out_ready;
  res_t   out_x_axis_x, out_x_axis_y, out_x_axis_z;
  res_t   out_y_axis_x, out_y_axis_y, out_y_axis_z;
  res_t   out_z_axis_x, out_z_axis_y, out_z_axis_z;
  res_t   out_trans_x, out_trans_y, out_trans_z;

  int fail_count;
  int outstanding;
  int matrices_checked;
  int limit_elems;
  int transforms_sent = 0;
  int directed_count = 0;
  int long_holds_done = 0;
  int cycle_count = 0;
  bit long_hold_req = 1'b0;

  always #4 clk = ~clk;

  quaternion_trs_model_matrix u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_quat_w    (in_quat_w),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_scale_x   (in_scale_x),
    .in_scale_y   (in_scale_y),
    .in_scale_z   (in_scale_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_x_axis_x (out_x_axis_x),
    .out_x_axis_y (out_x_axis_y),
    .out_x_axis_z (out_x_axis_z),
    .out_y_axis_x (out_y_axis_x),
    .out_y_axis_y (out_y_axis_y),
    .out_y_axis_z (out_y_axis_z),
    .out_z_axis_x (out_z_axis_x),
    .out_z_axis_y (out_z_axis_y),
    .out_z_axis_z (out_z_axis_z),
    .out_trans_x  (out_trans_x),
    .out_trans_y  (out_trans_y),
    .out_trans_z  (out_trans_z)
  );

  qtrs_matrix_checker u_matrix_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_scale_x       (in_scale_x),
    .in_scale_y       (in_scale_y),
    .in_scale_z       (in_scale_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_x_axis_x     (out_x_axis_x),
    .out_x_axis_y     (out_x_axis_y),
    .out_x_axis_z     (out_x_axis_z),
    .out_y_axis_x     (out_y_axis_x),
    .out_y_axis_y     (out_y_axis_y),
    .out_y_axis_z     (out_y_axis_z),
    .out_z_axis_x     (out_z_axis_x),
    .out_z_axis_y     (out_z_axis_y),
    .out_z_axis_z     (out_z_axis_z),
    .out_trans_x      (out_trans_x),
    .out_trans_y      (out_trans_y),
    .out_trans_z      (out_trans_z),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .matrices_checked (matrices_checked),
    .limit_elems      (limit_elems)
  );

  function automatic transform_t make_transform(
    input quat_t w, input quat_t x, input quat_t y, input quat_t z,
    input pos_t px, input pos_t py, input pos_t pz,
    input scale_t sx, input scale_t sy, input scale_t sz
  );
    transform_t t;
    t.w = w; t.x = x; t.y = y; t.z = z;
    t.px = px; t.py = py; t.pz = pz;
    t.sx = sx; t.sy = sy; t.sz = sz;
    return t;
  endfunction

  function automatic quat_t pick_quat();
    quat_t corner[7] = '{16'sh8000, -16'sd16384, -16'sd1, 16'sd0, 16'sd1, 16'sd16384,
                         16'sh7FFF};
    case ($urandom_range(0, 9))
      0:       return quat_t'($urandom);
      1:       return corner[$urandom_range(0, 6)];
      default: return quat_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic pos_t pick_pos();
    pos_t corner[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    if ($urandom_range(0, 9) == 0)
      return corner[$urandom_range(0, 3)];
    return pos_t'($urandom);
  endfunction

  // mostly near unit scale, some anywhere in range, a few at the corners
  function automatic scale_t pick_scale();
    scale_t corner[5] = '{24'h000000, 24'h000001, 24'h010000, 24'h800000, 24'hFFFFFF};
    case ($urandom_range(0, 9))
      6, 7, 8: return scale_t'($urandom);
      9:       return corner[$urandom_range(0, 4)];
      default: return scale_t'($urandom_range(0, 24'h03FFFF));
    endcase
  endfunction

  function automatic transform_t random_transform();
    return make_transform(pick_quat(), pick_quat(), pick_quat(), pick_quat(),
                          pick_pos(), pick_pos(), pick_pos(),
                          pick_scale(), pick_scale(), pick_scale());
  endfunction

  // hold each beat until accepted; valid stays high into the next beat when gap is zero
  task automatic offer(input transform_t t, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_quat_w  <= t.w;
    in_quat_x  <= t.x;
    in_quat_y  <= t.y;
    in_quat_z  <= t.z;
    in_pos_x   <= t.px;
    in_pos_y   <= t.py;
    in_pos_z   <= t.pz;
    in_scale_x <= t.sx;
    in_scale_y <= t.sy;
    in_scale_z <= t.sz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    transforms_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    transform_t directed[$];
    int burst_left;
    bit no_gap;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_quat_w  = '0;
    in_quat_x  = '0;
    in_quat_y  = '0;
    in_quat_z  = '0;
    in_pos_x   = '0;
    in_pos_y   = '0;
    in_pos_z   = '0;
    in_scale_x = '0;
    in_scale_y = '0;
    in_scale_z = '0;
    burst_left = 0;
    no_gap     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity and negated identity at unit scale, then the zero quaternion at mixed scale
    directed.push_back(make_transform(16384, 0, 0, 0, 0, 0, 0,
                                      24'h010000, 24'h010000, 24'h010000));
    directed.push_back(make_transform(-16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'hFFFF_FFFF, 24'h010000, 24'h010000, 24'h010000));
    directed.push_back(make_transform(0, 0, 0, 0, 32'h0001_0000, -32'sd65536, 1,
                                      24'h010000, 24'h020000, 24'h008000));
    // half turns about each axis
    directed.push_back(make_transform(0, 16384, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                                      24'h010000, 24'h010000, 24'h010000));
    directed.push_back(make_transform(0, 0, 16384, 0, 0, 0, 0,
                                      24'h018000, 24'h010000, 24'h000001));
    directed.push_back(make_transform(0, 0, 0, -16384, 0, 0, 0,
                                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    // eighth turn about z and a normalised mix
    directed.push_back(make_transform(15137, 0, 0, 6270, 32'h1234_5678, 32'hEDCB_A988, 0,
                                      24'h010000, 24'h010000, 24'h010000));
    directed.push_back(make_transform(8192, 8192, -8192, 8192, 0, 0, 0,
                                      24'h030000, 24'h000100, 24'h7FFFFF));
    // unnormalised quaternion, used as given
    directed.push_back(make_transform(16384, 16384, 0, 0, 0, 0, 0,
                                      24'h010000, 24'h010000, 24'h010000));
    // out-of-range components at maximum scale drive the largest magnitudes both ways
    directed.push_back(make_transform(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0,
                                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    directed.push_back(make_transform(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0,
                                      24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    directed.push_back(make_transform(16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 0, 0, 0,
                                      24'hFFFFFF, 24'h800000, 24'hFFFFFF));
    directed.push_back(make_transform(-1, -1, -1, -1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    // zero scale flattens every column
    directed.push_back(make_transform(16'sh8000, 16'sh7FFF, 1, -1, 0, 0, 0,
                                      24'h000000, 24'h000000, 24'h000000));
    // tiny components at large scale: small products of both signs near zero
    directed.push_back(make_transform(1, 1, 0, 1, 0, 0, 0,
                                      24'h400000, 24'h400000, 24'h400000));
    directed.push_back(make_transform(-1, 1, 1, 1, 0, 0, 0,
                                      24'h400000, 24'hC00000, 24'h400000));

    directed_count = directed.size();
    foreach (directed[i])
      offer(directed[i], $urandom_range(0, MAX_IDLE));
    drain();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (burst_left == 0) begin
        no_gap = ($urandom_range(0, 3) == 0);
        burst_left = $urandom_range(10, 60);
      end
      // long output stall while the input keeps streaming
      if (i == NUM_RANDOM / 3) begin
        long_hold_req = 1'b1;
        no_gap = 1'b1;
        burst_left = 40;
      end
      burst_left--;
      if (i == 2 * NUM_RANDOM / 3)
        drain();
      offer(random_transform(), no_gap ? 0 : $urandom_range(0, MAX_IDLE));
    end
    in_valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (4 * PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d transforms (%0d directed), compared %0d matrices.",
             transforms_sent, directed_count, matrices_checked);
    $display("%0d rotation elements hit the 32-bit limit; %0d long output stall(s).",
             limit_elems, long_holds_done);
    if (fail_count == 0)
      $display("quaternion_trs_model_matrix verification clean");
    else
      $display("quaternion_trs_model_matrix verification failed");
    $finish;
  end

  initial begin : receiver
    int stall;
    int mode_left;
    bit no_stall;
    out_ready = 1'b0;
    mode_left = 0;
    no_stall  = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        no_stall = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
        long_holds_done++;
      end else begin
        stall = no_stall ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_count, outstanding);
    $display("quaternion_trs_model_matrix verification failed");
    $finish;
  end

endmodule
